@@ src/stick_front_end_conditioner_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the stick front end conditioner
// Shorthand for clocked checks with synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef STICK_FRONT_END_CONDITIONER_UNIT_ASSERT_SVH
`define STICK_FRONT_END_CONDITIONER_UNIT_ASSERT_SVH

// Condition implies consequence in the same cycle
`define SFEC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle
`define SFEC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sfec_pkg.sv @@
// ---------------------------------------------------------------------------
// sfec_pkg
// Types and constants shared by the stick front end conditioner.
// ---------------------------------------------------------------------------
package sfec_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int OUT_W         = SAMPLE_BITS + 1;
  localparam int AXES          = 4;

  // Moving average window, power of two so the average is a shift
  localparam int SMOOTH_DEPTH  = 4;
  localparam int SMOOTH_SHIFT  = $clog2(SMOOTH_DEPTH);
  localparam int SLOT_W        = (SMOOTH_SHIFT > 0) ? SMOOTH_SHIFT : 1;
  localparam int SUM_W         = SAMPLE_BITS + SMOOTH_SHIFT;

  // Center capture length, power of two so the mean is a shift
  localparam int CAL_COUNT     = 8;
  localparam int CAL_SHIFT     = $clog2(CAL_COUNT);
  localparam int CAP_W         = SAMPLE_BITS + CAL_SHIFT;
  localparam int PHASE_W       = $clog2(CAL_COUNT + 2);

  localparam logic [PHASE_W-1:0] PHASE_IDLE  = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PHASE_SKIP  = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PHASE_FIRST = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] PHASE_LAST  = PHASE_W'(CAL_COUNT + 1);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK  = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(2048);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SAMPLE_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT_MASK    = 3'd0,
    REG_LEFT_X_CENTER  = 3'd1,
    REG_LEFT_Y_CENTER  = 3'd2,
    REG_RIGHT_X_CENTER = 3'd3,
    REG_RIGHT_Y_CENTER = 3'd4
  } cfg_reg_t;

  // Per-item controls broadcast to the axis lanes
  typedef struct packed {
    logic              step;
    logic [SLOT_W-1:0] slot;
    logic              clear;
    logic              accum;
    logic              finish;
  } axis_ctrl_t;

endpackage

@@ src/sfec_in_if.sv @@
// ---------------------------------------------------------------------------
// sfec_in_if
// Sample set channel: command bit and four raw ADC readings.
// ---------------------------------------------------------------------------
interface sfec_in_if import sfec_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SAMPLE_BITS-1:0] left_x_sample;
  logic [SAMPLE_BITS-1:0] left_y_sample;
  logic [SAMPLE_BITS-1:0] right_x_sample;
  logic [SAMPLE_BITS-1:0] right_y_sample;

  modport source (
    output valid, cmd, left_x_sample, left_y_sample, right_x_sample, right_y_sample,
    input  ready
  );
  modport sink (
    input  valid, cmd, left_x_sample, left_y_sample, right_x_sample, right_y_sample,
    output ready
  );
endinterface

@@ src/sfec_out_if.sv @@
// ---------------------------------------------------------------------------
// sfec_out_if
// Result channel: four signed, center-relative axis values.
// ---------------------------------------------------------------------------
interface sfec_out_if import sfec_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] left_x;
  logic signed [OUT_W-1:0] left_y;
  logic signed [OUT_W-1:0] right_x;
  logic signed [OUT_W-1:0] right_y;

  modport source (
    output valid, left_x, left_y, right_x, right_y,
    input  ready
  );
  modport sink (
    input  valid, left_x, left_y, right_x, right_y,
    output ready
  );
endinterface

@@ src/sfec_axis.sv @@
// ---------------------------------------------------------------------------
// sfec_axis
// One axis lane: moving average, optional inversion, center capture
// accumulator and active center, giving the signed center-relative value.
// ---------------------------------------------------------------------------
module sfec_axis import sfec_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  axis_ctrl_t              ctrl,
  input  logic                    invert,
  input  logic [SAMPLE_BITS-1:0]  raw,
  input  logic                    load,
  input  logic [SAMPLE_BITS-1:0]  load_value,
  output logic signed [OUT_W-1:0] diff
);

  logic [SAMPLE_BITS-1:0] hist_r [SMOOTH_DEPTH];
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic [CAP_W-1:0]       cap_total;
  logic [SAMPLE_BITS-1:0] center_r;
  logic [SAMPLE_BITS-1:0] avg;
  logic [SAMPLE_BITS-1:0] cond;
  logic [SAMPLE_BITS-1:0] new_center;
  logic [SAMPLE_BITS-1:0] center_use;

  // Slide the window: drop the oldest sample, add the new one
  always_comb begin
    sum_nxt    = sum_r - SUM_W'(hist_r[ctrl.slot]) + SUM_W'(raw);
    avg        = SAMPLE_BITS'(sum_nxt >> SMOOTH_SHIFT);
    cond       = invert ? (SAMPLE_MASK - avg) : avg;
    cap_total  = cap_r + CAP_W'(cond);
    new_center = SAMPLE_BITS'(cap_total >> CAL_SHIFT);
    center_use = ctrl.finish ? new_center : center_r;
    diff       = $signed({1'b0, cond}) - $signed({1'b0, center_use});
  end

  // Advance window, capture accumulator and center
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SMOOTH_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      sum_r    <= '0;
      cap_r    <= '0;
      center_r <= CENTER_RESET;
    end else begin
      if (ctrl.step) begin
        hist_r[ctrl.slot] <= raw;
        sum_r             <= sum_nxt;
        if (ctrl.clear) begin
          cap_r <= '0;
        end else if (ctrl.accum) begin
          cap_r <= cap_total;
        end
        if (ctrl.finish) begin
          center_r <= new_center;
        end
      end
      if (load) begin
        center_r <= load_value;
      end
    end
  end

endmodule

@@ src/stick_front_end_conditioner_unit.sv @@
// ---------------------------------------------------------------------------
// stick_front_end_conditioner_unit
// Two-stick conditioning front end: per-axis moving average, inversion,
// center subtraction and center capture.
//
//   channel  | direction | transaction
//   in_if    | in        | cmd + four 12-bit raw samples
//   out_if   | out       | four 13-bit signed axis values
//   cfg_*    | in        | write of invert mask or one center register
//
// One transaction is accepted per cycle unless a stalled result fills the input
// register; the result register behind it loads from it and offers the result.
// Items that start or run a center capture give no result, except the last
// capture item.
// Reset clears the sample history, sums, capture state, and sets centers to
// 2048.
// A stalled result holds the result register; the input register still takes
// one more transaction before in_if.ready drops.
// ---------------------------------------------------------------------------
`include "stick_front_end_conditioner_unit_assert.svh"

module stick_front_end_conditioner_unit import sfec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sfec_in_if.sink               in_if,
  sfec_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                    s1_valid_r;
  logic                    s1_cmd_r;
  logic [SAMPLE_BITS-1:0]  s1_samp_r [AXES];
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [OUT_W-1:0] out_r [AXES];
  logic signed [OUT_W-1:0] diff [AXES];
  logic [PHASE_W-1:0]      phase_r;
  logic [PHASE_W-1:0]      phase_nxt;
  logic [SLOT_W-1:0]       slot_r;
  logic [AXES-1:0]         invert_r;
  logic [AXES-1:0]         load;
  logic                    step;
  logic                    emit;
  logic                    in_accept;
  logic                    step_skip;
  logic                    step_last;
  axis_ctrl_t              ctrl;

  // Handshake
  assign step         = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || step;
  assign in_accept    = in_if.valid && in_if.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r     <= in_if.cmd;
      s1_samp_r[0] <= in_if.left_x_sample;
      s1_samp_r[1] <= in_if.left_y_sample;
      s1_samp_r[2] <= in_if.right_x_sample;
      s1_samp_r[3] <= in_if.right_y_sample;
    end
  end

  // Capture sequencing: start, skip one, accumulate, finish
  always_comb begin
    phase_nxt   = phase_r;
    emit        = 1'b0;
    ctrl.step   = step;
    ctrl.slot   = slot_r;
    ctrl.clear  = 1'b0;
    ctrl.accum  = 1'b0;
    ctrl.finish = 1'b0;
    if (phase_r == PHASE_IDLE) begin
      if (s1_cmd_r) begin
        phase_nxt = PHASE_SKIP;
      end else begin
        emit = 1'b1;
      end
    end else if (phase_r == PHASE_SKIP) begin
      ctrl.clear = 1'b1;
      phase_nxt  = PHASE_FIRST;
    end else if (phase_r == PHASE_LAST) begin
      ctrl.finish = 1'b1;
      emit        = 1'b1;
      phase_nxt   = PHASE_IDLE;
    end else begin
      ctrl.accum = 1'b1;
      phase_nxt  = phase_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_IDLE;
      slot_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      slot_r  <= (slot_r == SLOT_W'(SMOOTH_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  // Configuration decode
  always_comb begin
    load = '0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_X_CENTER:  load[0] = 1'b1;
        REG_LEFT_Y_CENTER:  load[1] = 1'b1;
        REG_RIGHT_X_CENTER: load[2] = 1'b1;
        REG_RIGHT_Y_CENTER: load[3] = 1'b1;
        default:            load    = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= '0;
    end else if (cfg_we && (cfg_index == REG_INVERT_MASK)) begin
      invert_r <= cfg_wdata[AXES-1:0];
    end
  end

  // Axis lanes
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    sfec_axis u_axis (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .invert     (invert_r[a]),
      .raw        (s1_samp_r[a]),
      .load       (load[a]),
      .load_value (cfg_wdata[SAMPLE_BITS-1:0]),
      .diff       (diff[a])
    );
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = emit;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      for (int i = 0; i < AXES; i++) begin
        out_r[i] <= diff[i];
      end
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.left_x  = out_r[0];
  assign out_if.left_y  = out_r[1];
  assign out_if.right_x = out_r[2];
  assign out_if.right_y = out_r[3];

  // Checks
  assign step_skip = step && (phase_r == PHASE_SKIP);
  assign step_last = step && (phase_r == PHASE_LAST);

  `SFEC_ASSERT_SAME(a_phase_range, 1'b1, phase_r <= PHASE_LAST, "capture phase out of range")
  `SFEC_ASSERT_NEXT(a_skip_then_first, step_skip, phase_r == PHASE_FIRST, "capture skip stuck")
  `SFEC_ASSERT_NEXT(a_finish_emits, step_last, out_valid_r && (phase_r == PHASE_IDLE), "no result")
  `SFEC_ASSERT_SAME(a_stall_full, !in_if.ready, s1_valid_r && out_valid_r, "input stalled early")

endmodule

@@ bench/tb_stick_front_end_conditioner_unit.sv @@
// ---------------------------------------------------------------------------
// Testbench for the stick front end conditioner
// Drives sample sets through the valid/ready input channel and predicts each
// result with an in-bench model of the moving average, inversion, center
// subtraction and center capture. Every result is checked field by field.
// A short directed table covers warm-up, field extremes and one capture.
// Random phases follow, each under a different register setting, with
// random idle gaps on both channels.
// ---------------------------------------------------------------------------
module tb_stick_front_end_conditioner_unit;
  import sfec_pkg::*;

  localparam int NUM_PHASES     = 6;
  localparam int RAND_PER_PHASE = 105;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int AXIS_IDX_W     = $clog2(AXES);

  typedef logic [AXES-1:0][SAMPLE_BITS-1:0] raw_set_t;
  typedef logic [AXES-1:0][OUT_W-1:0]       axis_set_t;

  typedef struct packed {
    logic             cmd;
    raw_set_t         raw;
    logic             typed;
    logic [OUT_W-1:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfec_in_if  in_ch();
  sfec_out_if out_ch();

  stick_front_end_conditioner_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the conditioner
  logic [SMOOTH_DEPTH-1:0][AXES-1:0][SAMPLE_BITS-1:0] win_hist;
  logic [AXES-1:0][SUM_W-1:0]       win_sum;
  logic [SLOT_W-1:0]                win_pos;
  logic [AXES-1:0][SAMPLE_BITS-1:0] ctr_now;
  logic [PHASE_W-1:0]               cal_phase;
  logic [AXES-1:0][CAP_W-1:0]       cal_acc;
  logic [AXES-1:0]                  inv_bits;

  axis_set_t expected_axes_q [$];
  stim_row_t directed_rows [$];

  string axis_name [AXES] = '{"left_x", "left_y", "right_x", "right_y"};

  bit steady = 1'b0;
  int err_count = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_captures = 0;
  int n_settings = 0;

  // Advance the predicted state by one sample set
  task automatic condition_set(input logic cmd, input raw_set_t raw,
                               output bit gives, output axis_set_t res);
    logic [AXES-1:0][SAMPLE_BITS-1:0] cond;
    logic [SAMPLE_BITS-1:0] avg;
    for (int a = 0; a < AXES; a++) begin
      win_sum[a] = win_sum[a] - win_hist[win_pos][a] + raw[a];
      win_hist[win_pos][a] = raw[a];
      avg = SAMPLE_BITS'(win_sum[a] / SMOOTH_DEPTH);
      cond[a] = inv_bits[a] ? SAMPLE_MASK - avg : avg;
    end
    win_pos = SLOT_W'((win_pos + 1) % SMOOTH_DEPTH);

    gives = 1'b1;
    if (cal_phase == PHASE_IDLE) begin
      if (cmd) begin
        cal_phase = PHASE_SKIP;
        gives = 1'b0;
      end
    end else if (cal_phase == PHASE_SKIP) begin
      cal_acc = '0;
      cal_phase = PHASE_FIRST;
      gives = 1'b0;
    end else begin
      for (int a = 0; a < AXES; a++) cal_acc[a] = cal_acc[a] + cond[a];
      if (cal_phase < PHASE_LAST) begin
        cal_phase = cal_phase + 1'b1;
        gives = 1'b0;
      end else begin
        // Load the captured means as the new centers
        for (int a = 0; a < AXES; a++) ctr_now[a] = SAMPLE_BITS'(cal_acc[a] / CAL_COUNT);
        cal_phase = PHASE_IDLE;
        n_captures++;
      end
    end

    for (int a = 0; a < AXES; a++) res[a] = {1'b0, cond[a]} - {1'b0, ctr_now[a]};
  endtask

  // Offer one sample set, hold it until accepted, then log its expected result if it gives one
  task automatic send_sample(input logic cmd, input raw_set_t raw,
                             input logic typed, input logic [OUT_W-1:0] want);
    int gap;
    bit gives;
    axis_set_t res;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.left_x_sample  <= raw[0];
    in_ch.left_y_sample  <= raw[1];
    in_ch.right_x_sample <= raw[2];
    in_ch.right_y_sample <= raw[3];
    do @(posedge clk); while (!in_ch.ready);
    condition_set(cmd, raw, gives, res);
    n_items++;
    if (gives) expected_axes_q.push_back(typed ? {AXES{want}} : res);
  endtask

  // Hold the input idle until every expected result is out, then settle
  task automatic wait_drained;
    in_ch.valid <= 1'b0;
    while (expected_axes_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Write one register; the caller drops cfg_we after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_INVERT_MASK: inv_bits = data[AXES-1:0];
      REG_LEFT_X_CENTER, REG_LEFT_Y_CENTER, REG_RIGHT_X_CENTER, REG_RIGHT_Y_CENTER:
        ctr_now[AXIS_IDX_W'(idx - REG_LEFT_X_CENTER)] = data[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endtask

  function automatic void add_row(input logic cmd, input int lx, input int ly,
                                  input int rx, input int ry,
                                  input logic typed, input int want);
    stim_row_t r;
    r.cmd   = cmd;
    r.raw   = {SAMPLE_BITS'(ry), SAMPLE_BITS'(rx), SAMPLE_BITS'(ly), SAMPLE_BITS'(lx)};
    r.typed = typed;
    r.want  = OUT_W'(want);
    directed_rows.push_back(r);
  endfunction

  // Reading near a rest position most of the time, else uniform or extreme
  function automatic logic [SAMPLE_BITS-1:0] draw_reading(input int rest);
    int pick;
    int v;
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      v = rest + int'($urandom_range(0, 128)) - 64;
      if (v < 0) v = 0;
      if (v > int'(SAMPLE_MASK)) v = int'(SAMPLE_MASK);
    end else if (pick < 17) begin
      v = $urandom_range(0, int'(SAMPLE_MASK));
    end else begin
      v = (pick == 17) ? 0 : int'(SAMPLE_MASK);
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Accept results with random stalls and check them in order
  always @(posedge clk) begin : result_check
    int stall_left;
    axis_set_t got;
    axis_set_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.right_y, out_ch.right_x, out_ch.left_y, out_ch.left_x};
        if (expected_axes_q.size() == 0) begin
          $display("%0t: result with none expected: lx %0d ly %0d rx %0d ry %0d", $time,
                   $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
          err_count++;
        end else begin
          want = expected_axes_q.pop_front();
          n_checked++;
          for (int a = 0; a < AXES; a++) begin
            if (got[a] !== want[a]) begin
              $display("%0t: %s mismatch: expected %0d, actual %0d", $time,
                       axis_name[a], $signed(want[a]), $signed(got[a]));
              err_count++;
            end
          end
        end
        stall_left = steady ? 0 : $urandom_range(0, 7);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("[stick_front_end_conditioner_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int rest [AXES];
    raw_set_t raw;
    logic cmd;
    logic [CFG_DATA_W-1:0] mask_data;
    logic [AXES-1:0][CFG_DATA_W-1:0] ctr_data;

    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= 1'b0;
    in_ch.left_x_sample  <= '0;
    in_ch.left_y_sample  <= '0;
    in_ch.right_x_sample <= '0;
    in_ch.right_y_sample <= '0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_INVERT_MASK;
    cfg_wdata            <= '0;

    win_hist  = '0;
    win_sum   = '0;
    win_pos   = '0;
    cal_phase = PHASE_IDLE;
    cal_acc   = '0;
    inv_bits  = '0;
    for (int a = 0; a < AXES; a++) ctr_now[a] = CENTER_RESET;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Warm-up from an all-zero history, full-scale steps, then a capture
    add_row(1'b0,    0,    0,    0,    0, 1'b1, -2048);
    add_row(1'b0, 4095, 4095, 4095, 4095, 1'b1, -1025);
    add_row(1'b0, 4095, 4095, 4095, 4095, 1'b1,    -1);
    add_row(1'b0, 4095, 4095, 4095, 4095, 1'b1,  1023);
    add_row(1'b0, 4095, 4095, 4095, 4095, 1'b1,  2047);
    add_row(1'b0,    0,    0,    0,    0, 1'b0,     0);
    add_row(1'b0,    0,    0,    0,    0, 1'b0,     0);
    add_row(1'b0,    0,    0,    0,    0, 1'b0,     0);
    add_row(1'b0,    0,    0,    0,    0, 1'b1, -2048);
    add_row(1'b0, 4095,    0,    1, 4094, 1'b0,     0);
    add_row(1'b0,    0, 4095, 4094,    1, 1'b0,     0);
    for (int k = 0; k < 3; k++) add_row(1'b0, 1000, 1000, 1000, 1000, 1'b0, 0);
    // Capture start, discarded item, eight accumulated items
    add_row(1'b1, 1000, 1000, 1000, 1000, 1'b0, 0);
    add_row(1'b0, 1000, 1000, 1000, 1000, 1'b0, 0);
    for (int k = 0; k < CAL_COUNT - 1; k++)
      add_row((k == 2), 1000, 1000, 1000, 1000, 1'b0, 0);
    add_row(1'b0, 1000, 1000, 1000, 1000, 1'b1, 0);

    foreach (directed_rows[i])
      send_sample(directed_rows[i].cmd, directed_rows[i].raw,
                  directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained;

      // Pick this phase's register setting, extremes first
      case (p)
        0: begin
          mask_data = '0;
          ctr_data  = '0;
        end
        1: begin
          mask_data = '1;
          ctr_data  = '1;
        end
        default: begin
          mask_data = CFG_DATA_W'($urandom);
          for (int a = 0; a < AXES; a++) ctr_data[a] = CFG_DATA_W'($urandom);
        end
      endcase
      write_reg(REG_INVERT_MASK, mask_data);
      write_reg(REG_LEFT_X_CENTER, ctr_data[0]);
      write_reg(REG_LEFT_Y_CENTER, ctr_data[1]);
      write_reg(REG_RIGHT_X_CENTER, ctr_data[2]);
      write_reg(REG_RIGHT_Y_CENTER, ctr_data[3]);
      // Writes to unmapped indexes must leave the setting untouched
      if (p == 2) begin
        for (int k = int'(REG_RIGHT_Y_CENTER) + 1; k < (1 << CFG_IDX_W); k++)
          write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
      end
      cfg_we <= 1'b0;
      n_settings++;

      for (int a = 0; a < AXES; a++) rest[a] = $urandom_range(0, int'(SAMPLE_MASK));

      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        if (i % 32 == 0) steady = ($urandom_range(0, 3) == 0);
        // Hold off the sender until the result channel drains
        if (i == RAND_PER_PHASE / 2) wait_drained;
        cmd = ($urandom_range(0, 11) == 0);
        for (int a = 0; a < AXES; a++) raw[a] = draw_reading(rest[a]);
        send_sample(cmd, raw, 1'b0, '0);
      end

      // Finish any capture in flight before the next setting
      while (cal_phase != PHASE_IDLE) begin
        for (int a = 0; a < AXES; a++) raw[a] = draw_reading(rest[a]);
        send_sample(1'b0, raw, 1'b0, '0);
      end
    end

    steady = 1'b0;
    wait_drained;

    $display("Sent %0d sample sets under %0d register settings plus reset defaults.",
             n_items, n_settings);
    $display("Checked %0d results, %0d of them closing a center capture; %0d errors.",
             n_checked, n_captures, err_count);
    if (err_count == 0) begin
      $display("[stick_front_end_conditioner_unit] OK");
    end else begin
      $display("[stick_front_end_conditioner_unit] ERROR");
    end
    $finish;
  end

endmodule
